[hdl/assert_macros.svh]
// Assertion macros shared by the positional list store RTL.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/pls_pkg.sv]
// Package for the positional list store: sizes, word types, mode and status codes.
// Used by pls_cell, pls_ctrl and positional_list_store.
package pls_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ELEM_WIDTH = 8;
  localparam int unsigned POS_W      = $clog2(DEPTH + 2);
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_REAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_REAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_AT    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    elem_t             value;
  } cmd_word_t;

  typedef struct packed {
    elem_t             removed_value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count;
  } res_word_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] idx;
    elem_t            value;
  } cell_ctl_t;

endpackage

[hdl/pls_cell.sv]
// One storage cell of the positional list store chain.
// Depends on pls_pkg for the element and control types.
module pls_cell
  import pls_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  cell_ctl_t        ctl_i,
  input  elem_t            left_i,
  input  elem_t            right_i,
  output elem_t            data_o,
  output elem_t            hit_o
);

  elem_t data_q, data_d;

  // Shift toward the rear on insert, toward the front on remove
  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (cell_idx_i > ctl_i.idx) begin
        data_d = left_i;
      end else if (cell_idx_i == ctl_i.idx) begin
        data_d = ctl_i.value;
      end
    end else if (ctl_i.rem) begin
      if (cell_idx_i >= ctl_i.idx) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Offer the held element when this cell is the one addressed
  assign hit_o  = (cell_idx_i == ctl_i.idx) ? data_q : '0;
  assign data_o = data_q;

endmodule

[hdl/pls_ctrl.sv]
// Command decode, occupancy count and result register of the positional list store.
// Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_ctrl
  import pls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cmd_word_t cmd_i,
  input  elem_t     rd_value_i,
  output cell_ctl_t ctl_o,
  output logic      busy_o,
  output logic      result_valid_o,
  output res_word_t result_o
);

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             res_valid_q;
  res_word_t        res_q;
  logic             accept;
  logic             full, empty;
  logic [CMP_W-1:0] pos_x, occ_x;
  status_e          status;
  cell_ctl_t        ctl;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (occ_q == CNT_W'(DEPTH));
  assign empty  = (occ_q == '0);
  assign pos_x  = CMP_W'(cmd_i.position);
  assign occ_x  = CMP_W'(occ_q);

  // Decode the word into a cell command and a status
  always_comb begin
    status    = ST_OK;
    ctl.ins   = 1'b0;
    ctl.rem   = 1'b0;
    ctl.idx   = '0;
    ctl.value = cmd_i.value;
    case (cmd_i.mode)
      MODE_ADD_FRONT: begin
        if (full) status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      MODE_ADD_REAR: begin
        ctl.idx = IDX_W'(occ_q);
        if (full) status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      MODE_REM_FRONT: begin
        if (empty) status = ST_UNDER;
        else ctl.rem = 1'b1;
      end
      MODE_REM_REAR: begin
        ctl.idx = IDX_W'(occ_q - CNT_W'(1));
        if (empty) status = ST_UNDER;
        else ctl.rem = 1'b1;
      end
      MODE_INS_AT: begin
        ctl.idx = IDX_W'(pos_x - CMP_W'(1));
        if (pos_x == '0 || pos_x > occ_x + CMP_W'(1)) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      MODE_REM_AT: begin
        ctl.idx = IDX_W'(pos_x - CMP_W'(1));
        if (pos_x == '0 || pos_x > occ_x) status = ST_RANGE;
        else ctl.rem = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Gate the cell command with the accept
  always_comb begin
    ctl_o     = ctl;
    ctl_o.ins = ctl.ins && accept;
    ctl_o.rem = ctl.rem && accept;
  end

  // Advance the occupancy count
  always_comb begin
    occ_d = occ_q;
    if (ctl_o.ins) occ_d = occ_q + CNT_W'(1);
    else if (ctl_o.rem) occ_d = occ_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      res_valid_q <= accept;
    end
  end

  // Hold the result word for its one strobe cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.removed_value <= ctl.rem ? rd_value_i : '0;
      res_q.status        <= status;
      res_q.count         <= occ_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `ASSERT_CLK(a_occ_bound, occ_q <= CNT_W'(DEPTH), "occupancy above depth")
  `ASSERT_NEVER(a_ins_rem_excl, ctl_o.ins && ctl_o.rem, "insert and remove together")
  `ASSERT_CLK(a_strobe_follows, result_valid_o == $past(accept), "result strobe lost or invented")
  `ASSERT_CLK(a_count_matches, result_valid_o |-> result_o.count == occ_q, "count differs from occupancy")
  `ASSERT_CLK(a_err_holds, (accept && status != ST_OK) |=> $stable(occ_q), "error changed the store")

endmodule

[hdl/positional_list_store.sv]
// Top level of the positional list store: a chain of DEPTH cells under one controller.
// Depends on pls_pkg, pls_cell and pls_ctrl.
//
//  channel   ports                          handshake
//  command   start_i, cmd_i, busy_o         taken when start_i high and busy_o low
//  result    result_valid_o, result_o       one-cycle strobe, cannot be held off
//
// One word is taken every cycle; busy_o stays low.
// Its result appears in the cycle after acceptance, from the result register in pls_ctrl.
// Reset clears the count to zero; cell contents stay undefined until written.
// No stalls: the receiver must take each result in its strobe cycle.
module positional_list_store
  import pls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cmd_word_t cmd_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output res_word_t result_o
);

  cell_ctl_t ctl;
  elem_t     cell_data [DEPTH];
  elem_t     cell_hit  [DEPTH];
  elem_t     rd_value;

  pls_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .rd_value_i     (rd_value),
    .ctl_o          (ctl),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Build the row of cells, each linked to its neighbors; the end cells see zero past the ends
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    elem_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    pls_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(k)),
      .ctl_i      (ctl),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // Merge the addressed cell's element
  always_comb begin
    rd_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_value = rd_value | cell_hit[k];
    end
  end

endmodule

[test/tb_positional_list_store.sv]
// Testbench for positional_list_store: directed and random list operations, each result
// checked against an in-bench queue model of the list. Depends on pls_pkg and the RTL.
module tb_positional_list_store;
  import pls_pkg::*;

  // Spare mode codes: the block takes them and changes nothing
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int unsigned       DRAIN_LIMIT  = 64;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  cmd_word_t cmd_i   = '0;
  logic      busy_o;
  logic      result_valid_o;
  res_word_t result_o;

  elem_t     list_q[$];         // list contents as the block should hold them
  res_word_t pending_results[$];
  int        mismatch_cnt = 0;

  positional_list_store dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one operation to the list model and return the word the block should give
  function automatic res_word_t predict_list_op(cmd_word_t w);
    res_word_t r;
    int        occ;
    int        pos;
    r   = '0;
    occ = list_q.size();
    pos = int'(w.position);
    r.status = ST_OK;
    case (w.mode)
      MODE_ADD_FRONT, MODE_ADD_REAR: begin
        if (occ >= DEPTH) r.status = ST_FULL;
        else if (w.mode == MODE_ADD_FRONT) list_q.push_front(w.value);
        else list_q.push_back(w.value);
      end
      MODE_REM_FRONT: begin
        if (occ == 0) r.status = ST_UNDER;
        else r.removed_value = list_q.pop_front();
      end
      MODE_REM_REAR: begin
        if (occ == 0) r.status = ST_UNDER;
        else r.removed_value = list_q.pop_back();
      end
      MODE_INS_AT: begin
        // range check wins over the full check
        if (pos < 1 || pos > occ + 1) r.status = ST_RANGE;
        else if (occ >= DEPTH) r.status = ST_FULL;
        else list_q.insert(pos - 1, w.value);
      end
      MODE_REM_AT: begin
        if (pos < 1 || pos > occ) begin
          r.status = ST_RANGE;
        end else begin
          r.removed_value = list_q[pos - 1];
          list_q.delete(pos - 1);
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_q.size());
    return r;
  endfunction

  function automatic cmd_word_t make_word(logic [MODE_W-1:0] mode, int pos, elem_t value);
    cmd_word_t w;
    w.mode     = mode;
    w.position = POS_W'(pos);
    w.value    = value;
    return w;
  endfunction

  // Send one word: idle at random, hold start until the block takes it, then predict.
  // Entered and left right after a rising edge.
  task automatic send_word(input cmd_word_t w, input int idle_pct);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= w;
    while (!taken) begin
      @(negedge clk_i);
      if (!busy_o) begin
        taken = 1'b1;
        pending_results.push_back(predict_list_op(w));
      end
      @(posedge clk_i);
    end
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Check each result word against the oldest expectation
  always @(negedge clk_i) begin
    res_word_t exp_w;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result word expected none actual %h", $time, result_o);
      end else begin
        exp_w = pending_results.pop_front();
        report_field("removed_value", exp_w.removed_value, result_o.removed_value);
        report_field("status", exp_w.status, result_o.status);
        report_field("count", exp_w.count, result_o.count);
      end
    end
  end

  // Underflow and range errors on the empty store, plus both spare modes
  task automatic test_empty_errors();
    send_word(make_word(MODE_REM_FRONT, 0, 8'h00), 0);
    send_word(make_word(MODE_REM_REAR, 31, 8'hFF), 0);
    send_word(make_word(MODE_REM_AT, 1, 8'h00), 0);
    send_word(make_word(MODE_INS_AT, 0, 8'hFF), 0);
    send_word(make_word(MODE_SPARE_A, 3, 8'h11), 0);
    send_word(make_word(MODE_SPARE_B, 16, 8'hAA), 0);
  endtask

  // Fill to DEPTH with every add mode, then hit the full and range cases
  task automatic test_fill_and_full();
    int    occ;
    elem_t v;
    for (int i = 0; i < DEPTH; i++) begin
      occ = list_q.size();
      v   = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : elem_t'($urandom_range(255));
      case (i % 3)
        0: send_word(make_word(MODE_INS_AT, occ / 2 + 1, v), 0);
        1: send_word(make_word(MODE_ADD_FRONT, 0, v), 0);
        default: send_word(make_word(MODE_ADD_REAR, 0, v), 0);
      endcase
    end
    send_word(make_word(MODE_ADD_REAR, 0, 8'h55), 0);
    send_word(make_word(MODE_INS_AT, DEPTH + 1, 8'h55), 0);
    send_word(make_word(MODE_INS_AT, DEPTH + 2, 8'h55), 0);
  endtask

  // Positional removals at the edges of the range
  task automatic test_remove_at_edges();
    send_word(make_word(MODE_REM_AT, DEPTH, 8'h00), 0);
    send_word(make_word(MODE_REM_AT, 0, 8'h00), 0);
    send_word(make_word(MODE_REM_AT, DEPTH, 8'h00), 0);
    send_word(make_word(MODE_REM_AT, 1, 8'h00), 0);
  endtask

  // Random traffic steered toward a moving fill target, with some noise words
  task automatic test_random_traffic(input int n_words, input int idle_pct);
    int                target;
    int                occ;
    int                grow_pct;
    int                pos;
    logic [MODE_W-1:0] mode;
    target = 0;
    for (int i = 0; i < n_words; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(3))
          0: target = 0;
          1: target = DEPTH;
          default: target = $urandom_range(DEPTH);
        endcase
      end
      occ = list_q.size();
      if ($urandom_range(9) == 0) begin
        mode = MODE_W'($urandom_range(7));
        pos  = $urandom_range(31);
      end else begin
        grow_pct = (occ < target) ? 75 : (occ > target) ? 25 : 50;
        if ($urandom_range(99) < grow_pct) begin
          case ($urandom_range(2))
            0: mode = MODE_ADD_FRONT;
            1: mode = MODE_ADD_REAR;
            default: mode = MODE_INS_AT;
          endcase
        end else begin
          case ($urandom_range(2))
            0: mode = MODE_REM_FRONT;
            1: mode = MODE_REM_REAR;
            default: mode = MODE_REM_AT;
          endcase
        end
        if ($urandom_range(9) == 0) pos = $urandom_range(31);
        else if (mode == MODE_INS_AT) pos = $urandom_range(1, occ + 1);
        else if (occ > 0) pos = $urandom_range(1, occ);
        else pos = $urandom_range(31);
      end
      send_word(make_word(mode, pos, elem_t'($urandom_range(255))), idle_pct);
    end
  endtask

  initial begin
    int waited;
    waited = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_errors();
    test_fill_and_full();
    test_remove_at_edges();
    test_random_traffic(340, 0);
    test_random_traffic(340, 68);
    test_random_traffic(340, 27);

    // Drop start and let the last words come back
    start_i <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_cnt += pending_results.size();
      $display("%0t: result words expected %0d actual 0", $time, pending_results.size());
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: end the run if it hangs
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
